/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked property on the rising clock, off while reset is low.
`define WJF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset.
`define WJF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/core/wjf_pkg.sv */
// Shared types and constants for the wire junction finder.
package wjf_pkg;
    localparam int MAX_WIRES  = 256;
    localparam int WIRE_AW    = $clog2(MAX_WIRES);
    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int COORD_W    = 24;
    localparam int TOL_W      = 20;
    localparam int MAXJ_W     = 7;
    localparam logic [1:0] JUNCTION_WIRES = 2'd3;

    localparam logic REG_TOLERANCE     = 1'b0;
    localparam logic REG_MAX_JUNCTIONS = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 20'd100;
    localparam logic [MAXJ_W-1:0] MAXJ_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CAND,
        ST_CAND_W,
        ST_SCAN,
        ST_DRAIN,
        ST_NEAR,
        ST_NEAR_W,
        ST_NEXT,
        ST_OUT,
        ST_OUT_W,
        ST_HOLD
    } wjf_state_t;
endpackage

/* rtl/core/wire_junction_finder_unit.sv */
// Top level of the wire junction finder: wire store, search sequencer, result port.
// Wire junction finder. Wires load one item per cycle into a 256-entry wire memory
// (both endpoints in one word); wires past 256 are dropped and flag overflow on the
// results. The item with s_tlast set is stored, then starts the search, and no input
// is taken until the last result of that search is delivered. For each stored endpoint
// in load order (end A, then end B) the sequencer fetches it (ST_CAND, ST_CAND_W), then
// streams every stored wire through a 3-stage squared-distance pipeline; a new junction
// is first checked against the earlier junctions in the 64-entry junction memory. Each
// result is read out through ST_OUT and ST_OUT_W and held in ST_HOLD until accepted.
// A search with no junction gives one result with found low.
// The wire memory and the junction memory each have a single read port.
`include "assert_macros.svh"
module wire_junction_finder_unit
    import wjf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [19:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // end_a_x [23:0], end_a_y [47:24], end_b_x [71:48], end_b_y [95:72]
    input  logic [95:0] s_tdata,
    input  logic        s_tlast,   // final_wire
    output logic        m_tvalid,
    input  logic        m_tready,
    // point_x [23:0], point_y [47:24]
    output logic [47:0] m_tdata,
    // found [0], overflow [1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast    // end_of_list
);

    // configuration
    logic [TOL_W-1:0]   tol_reg;
    logic [MAXJ_W-1:0]  maxj_reg;
    logic [2*TOL_W-1:0] tolsq_reg;

    // sequencer
    wjf_state_t state_reg, state_next;
    logic [WIRE_AW:0]  wcnt_reg;
    logic              drop_reg;
    logic [PT_AW:0]    fcnt_reg;
    logic [PT_AW:0]    limit_reg;
    logic [WIRE_AW:0]  cand_i_reg;
    logic              cand_e_reg;
    logic signed [COORD_W-1:0] cand_x_reg, cand_y_reg;
    logic [WIRE_AW:0]  scan_j_reg;
    logic [1:0]        hits_reg;
    logic [PT_AW:0]    nj_reg;
    logic [PT_AW:0]    k_reg;

    // memories
    logic [95:0] wmem [MAX_WIRES];
    logic [95:0] wrd_reg;
    logic [47:0] fmem [MAX_POINTS];
    logic [47:0] frd_reg;

    // distance pipeline
    logic rdv_reg, s1v_reg, s2v_reg;
    logic signed [COORD_W:0] dxa_reg, dya_reg, dxb_reg, dyb_reg;
    logic [2*COORD_W:0] sqxa_reg, sqya_reg, sqxb_reg, sqyb_reg;

    // output register
    logic        out_v_reg;
    logic [47:0] out_d_reg;
    logic        out_found_reg, out_last_reg, out_ovf_reg;

    // control decoded from state
    logic             in_acc;
    logic [WIRE_AW-1:0] wrd_addr;
    logic             wrd_en;
    logic [PT_AW-1:0] frd_addr;
    logic             f_we;
    logic             near_hit;
    logic             out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // near test against an earlier junction
    logic signed [COORD_W:0] ndx, ndy;
    logic [COORD_W:0] nax, nay;
    always_comb begin
        ndx = {frd_reg[23], frd_reg[23:0]} - {cand_x_reg[23], cand_x_reg};
        ndy = {frd_reg[47], frd_reg[47:24]} - {cand_y_reg[23], cand_y_reg};
        nax = ndx[COORD_W] ? (-ndx) : ndx;
        nay = ndy[COORD_W] ? (-ndy) : ndy;
        near_hit = (nax < {5'd0, tol_reg}) && (nay < {5'd0, tol_reg});
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                if (cand_i_reg >= wcnt_reg || fcnt_reg >= limit_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_CAND_W;
                end
            end
            ST_CAND_W: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_j_reg == wcnt_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rdv_reg && !s1v_reg && !s2v_reg) begin
                    state_next = (hits_reg == JUNCTION_WIRES) ? ST_NEAR : ST_NEXT;
                end
            end
            ST_NEAR: begin
                state_next = (nj_reg == fcnt_reg) ? ST_NEXT : ST_NEAR_W;
            end
            ST_NEAR_W: state_next = near_hit ? ST_NEXT : ST_NEAR;
            ST_NEXT:   state_next = ST_CAND;
            ST_OUT:    state_next = ST_OUT_W;
            ST_OUT_W:  state_next = ST_HOLD;
            ST_HOLD: begin
                if (out_acc) begin
                    state_next = out_last_reg ? ST_LOAD : ST_OUT;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        wrd_en   = 1'b0;
        wrd_addr = scan_j_reg[WIRE_AW-1:0];
        frd_addr = k_reg[PT_AW-1:0];
        f_we     = 1'b0;
        unique case (state_reg)
            ST_LOAD:   s_tready = 1'b1;
            ST_CAND: begin
                wrd_addr = cand_i_reg[WIRE_AW-1:0];
            end
            ST_SCAN:   wrd_en = 1'b1;
            ST_NEAR: begin
                frd_addr = nj_reg[PT_AW-1:0];
                f_we     = (nj_reg == fcnt_reg);
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg  <= TOL_RESET;
            maxj_reg <= MAXJ_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TOLERANCE:     tol_reg  <= cfg_wdata;
                REG_MAX_JUNCTIONS: maxj_reg <= cfg_wdata[MAXJ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        tolsq_reg <= tol_reg * tol_reg;
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (in_acc && !wcnt_reg[WIRE_AW]) begin
            wmem[wcnt_reg[WIRE_AW-1:0]] <= s_tdata;
        end
        wrd_reg <= wmem[wrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (f_we) begin
            fmem[fcnt_reg[PT_AW-1:0]] <= {cand_y_reg, cand_x_reg};
        end
        frd_reg <= fmem[frd_addr];
    end

    // distance pipeline: differences, squares, compare
    logic signed [2*COORD_W+1:0] pxa, pya, pxb, pyb;
    logic [2*COORD_W+1:0] suma, sumb;
    logic wire_hit;
    always_comb begin
        pxa = dxa_reg * dxa_reg;
        pya = dya_reg * dya_reg;
        pxb = dxb_reg * dxb_reg;
        pyb = dyb_reg * dyb_reg;
        suma = {1'b0, sqxa_reg} + {1'b0, sqya_reg};
        sumb = {1'b0, sqxb_reg} + {1'b0, sqyb_reg};
        wire_hit = (suma < {10'd0, tolsq_reg}) || (sumb < {10'd0, tolsq_reg});
    end

    always_ff @(posedge aclk) begin
        dxa_reg  <= {wrd_reg[23], wrd_reg[23:0]}   - {cand_x_reg[23], cand_x_reg};
        dya_reg  <= {wrd_reg[47], wrd_reg[47:24]}  - {cand_y_reg[23], cand_y_reg};
        dxb_reg  <= {wrd_reg[71], wrd_reg[71:48]}  - {cand_x_reg[23], cand_x_reg};
        dyb_reg  <= {wrd_reg[95], wrd_reg[95:72]}  - {cand_y_reg[23], cand_y_reg};
        sqxa_reg <= pxa[2*COORD_W:0];
        sqya_reg <= pya[2*COORD_W:0];
        sqxb_reg <= pxb[2*COORD_W:0];
        sqyb_reg <= pyb[2*COORD_W:0];
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            wcnt_reg   <= '0;
            drop_reg   <= 1'b0;
            fcnt_reg   <= '0;
            limit_reg  <= '0;
            cand_i_reg <= '0;
            cand_e_reg <= 1'b0;
            scan_j_reg <= '0;
            hits_reg   <= '0;
            nj_reg     <= '0;
            k_reg      <= '0;
            rdv_reg    <= 1'b0;
            s1v_reg    <= 1'b0;
            s2v_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= wrd_en;
            s1v_reg   <= rdv_reg;
            s2v_reg   <= s1v_reg;
            if (s2v_reg && wire_hit && hits_reg != JUNCTION_WIRES) begin
                hits_reg <= hits_reg + 1'b1;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (wcnt_reg[WIRE_AW]) begin
                            drop_reg <= 1'b1;
                        end else begin
                            wcnt_reg <= wcnt_reg + 1'b1;
                        end
                        if (s_tlast) begin
                            limit_reg  <= (maxj_reg > 7'(MAX_POINTS)) ? (PT_AW+1)'(MAX_POINTS)
                                                                       : maxj_reg[PT_AW:0];
                            fcnt_reg   <= '0;
                            cand_i_reg <= '0;
                            cand_e_reg <= 1'b0;
                        end
                    end
                end
                ST_CAND_W: begin
                    cand_x_reg <= cand_e_reg ? wrd_reg[71:48] : wrd_reg[23:0];
                    cand_y_reg <= cand_e_reg ? wrd_reg[95:72] : wrd_reg[47:24];
                    scan_j_reg <= '0;
                    hits_reg   <= '0;
                    nj_reg     <= '0;
                end
                ST_SCAN:  scan_j_reg <= scan_j_reg + 1'b1;
                ST_NEAR: begin
                    if (f_we) begin
                        fcnt_reg <= fcnt_reg + 1'b1;
                    end
                end
                ST_NEAR_W: nj_reg <= nj_reg + 1'b1;
                ST_NEXT: begin
                    cand_e_reg <= ~cand_e_reg;
                    if (cand_e_reg) begin
                        cand_i_reg <= cand_i_reg + 1'b1;
                    end
                end
                ST_CAND: begin
                    k_reg <= '0;
                end
                ST_OUT_W: begin
                    out_v_reg     <= 1'b1;
                    out_found_reg <= (fcnt_reg != '0);
                    out_d_reg     <= (fcnt_reg != '0) ? frd_reg : '0;
                    out_last_reg  <= (fcnt_reg == '0) || (k_reg + 1'b1 == fcnt_reg);
                    out_ovf_reg   <= drop_reg;
                end
                ST_HOLD: begin
                    if (out_acc) begin
                        out_v_reg <= 1'b0;
                        k_reg     <= k_reg + 1'b1;
                        if (out_last_reg) begin
                            wcnt_reg <= '0;
                            drop_reg <= 1'b0;
                            fcnt_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = {out_ovf_reg, out_found_reg};
    assign m_tlast  = out_last_reg;

    `WJF_ASSERT(a_fcnt_limit, aclk, aresetn, fcnt_reg <= limit_reg || state_reg == ST_LOAD, "junction count above limit")
    `WJF_ASSERT(a_fwrite_room, aclk, aresetn, f_we |-> fcnt_reg < limit_reg, "junction write past limit")
    `WJF_ASSERT(a_clear_after, aclk, aresetn, (out_acc && m_tlast) |=> (wcnt_reg == '0 && fcnt_reg == '0), "store not emptied after search")
    `WJF_ASSERT(a_no_load_busy, aclk, aresetn, m_tvalid |-> !s_tready, "input taken while results pending")

endmodule
